// ===== hdl/rhc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg
// shared types and constants of the rgb to hsv converter
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int CHAN_W   = 17;
    localparam int HUE_W    = 15;
    localparam int HQ_W     = 12;       // hue quotient, at most 3840
    localparam int HNUM_W   = CHAN_W + HQ_W;

    localparam logic [HQ_W-1:0]   HUE_SIXTH = 12'd3840;
    localparam logic [HUE_W-1:0]  HUE_GREEN = 15'd7680;
    localparam logic [HUE_W-1:0]  HUE_BLUE  = 15'd15360;
    localparam logic [HUE_W-1:0]  HUE_FULL  = 15'd23040;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    // one item in flight through the divide stages
    typedef struct packed {
        logic              ok;        // all channels within range
        logic              zero_c;    // grey pixel
        sector_t           sector;
        logic              neg;       // channel difference is negative
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] hrem;      // hue partial remainder
        logic [HQ_W-1:0]   hlow;      // hue numerator bits not yet used
        logic [HQ_W-1:0]   hq;
        logic [CHAN_W-1:0] c;         // hue divisor
        logic [CHAN_W-1:0] srem;      // saturation partial remainder
        logic [CHAN_W-1:0] sq;
    } item_t;

endpackage

// ===== hdl/rhc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_front
// input register, max/min/sector search and hue numerator multiply
// ----------------------------------------------------------------------------
module rhc_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_vld,
    input  logic [rhc_pkg::CHAN_W-1:0] red,
    input  logic [rhc_pkg::CHAN_W-1:0] green,
    input  logic [rhc_pkg::CHAN_W-1:0] blue,
    output logic                       out_vld,
    output rhc_pkg::item_t             out_item
);
    import rhc_pkg::*;

    localparam int CMP_W = CHAN_W + 9;
    localparam logic [CMP_W-1:0] ONE = CMP_W'(1) << FRAC_BITS;

    logic [2:0]        vld_reg;
    logic [CHAN_W-1:0] r_reg, g_reg, b_reg;

    logic              ok_reg, ok_next;
    sector_t           sec_reg, sec_next;
    logic              neg_reg, neg_next;
    logic [CHAN_W-1:0] mx_reg, mx_next, c_reg, c_next, mag_reg, mag_next;
    logic [CHAN_W-1:0] mn;

    item_t             item_reg, item_next;
    logic [HNUM_W-1:0] hnum;

    always_comb
    begin
        ok_next = (CMP_W'(r_reg) <= ONE) && (CMP_W'(g_reg) <= ONE)
               && (CMP_W'(b_reg) <= ONE);
        mx_next = r_reg;
        if (g_reg > mx_next) mx_next = g_reg;
        if (b_reg > mx_next) mx_next = b_reg;
        mn = r_reg;
        if (g_reg < mn) mn = g_reg;
        if (b_reg < mn) mn = b_reg;
        c_next = mx_next - mn;
        if (mx_next == r_reg)
        begin
            sec_next = SEC_RED;
            neg_next = b_reg > g_reg;
            mag_next = neg_next ? b_reg - g_reg : g_reg - b_reg;
        end
        else if (mx_next == g_reg)
        begin
            sec_next = SEC_GREEN;
            neg_next = r_reg > b_reg;
            mag_next = neg_next ? r_reg - b_reg : b_reg - r_reg;
        end
        else
        begin
            sec_next = SEC_BLUE;
            neg_next = g_reg > r_reg;
            mag_next = neg_next ? g_reg - r_reg : r_reg - g_reg;
        end
    end

    always_comb
    begin
        hnum             = HNUM_W'(mag_reg) * HNUM_W'(HUE_SIXTH);
        item_next.ok     = ok_reg;
        item_next.zero_c = (c_reg == '0);
        item_next.sector = sec_reg;
        item_next.neg    = neg_reg;
        item_next.mx     = mx_reg;
        item_next.hrem   = hnum[HNUM_W-1:HQ_W];
        item_next.hlow   = hnum[HQ_W-1:0];
        item_next.hq     = '0;
        item_next.c      = c_reg;
        item_next.srem   = c_reg;
        item_next.sq     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg    <= red;
            g_reg    <= green;
            b_reg    <= blue;
            ok_reg   <= ok_next;
            sec_reg  <= sec_next;
            neg_reg  <= neg_next;
            mx_reg   <= mx_next;
            c_reg    <= c_next;
            mag_reg  <= mag_next;
            item_reg <= item_next;
        end
    end

    assign out_vld  = vld_reg[2];
    assign out_item = item_reg;

endmodule

// ===== hdl/rhc_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_div_stage
// one restoring divide step for saturation and for hue, each enabled by a parameter, registered
// ----------------------------------------------------------------------------
module rhc_div_stage #(
    parameter bit DO_SAT    = 1'b1,
    parameter bit SAT_FIRST = 1'b0,
    parameter bit DO_HUE    = 1'b1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  rhc_pkg::item_t in_item,
    output logic           out_vld,
    output rhc_pkg::item_t out_item
);
    import rhc_pkg::*;

    logic          vld_reg;
    item_t         item_reg, item_next;
    logic [CHAN_W:0] st, ht;

    always_comb
    begin
        item_next = in_item;
        st = SAT_FIRST ? {1'b0, in_item.srem} : {in_item.srem, 1'b0};
        ht = {in_item.hrem, in_item.hlow[HQ_W-1]};
        if (DO_SAT)
        begin
            if (st >= {1'b0, in_item.mx})
            begin
                item_next.srem = CHAN_W'(st - {1'b0, in_item.mx});
                item_next.sq   = {in_item.sq[CHAN_W-2:0], 1'b1};
            end
            else
            begin
                item_next.srem = st[CHAN_W-1:0];
                item_next.sq   = {in_item.sq[CHAN_W-2:0], 1'b0};
            end
        end
        if (DO_HUE)
        begin
            item_next.hlow = {in_item.hlow[HQ_W-2:0], 1'b0};
            if (ht >= {1'b0, in_item.c})
            begin
                item_next.hrem = CHAN_W'(ht - {1'b0, in_item.c});
                item_next.hq   = {in_item.hq[HQ_W-2:0], 1'b1};
            end
            else
            begin
                item_next.hrem = ht[CHAN_W-1:0];
                item_next.hq   = {in_item.hq[HQ_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

// ===== hdl/rhc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_back
// sector offset, special cases and output register
// ----------------------------------------------------------------------------
module rhc_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_vld,
    input  rhc_pkg::item_t             in_item,
    output logic                       out_vld,
    output logic                       valid_res,
    output logic [rhc_pkg::HUE_W-1:0]  hue,
    output logic [rhc_pkg::CHAN_W-1:0] saturation,
    output logic [rhc_pkg::CHAN_W-1:0] brightness
);
    import rhc_pkg::*;

    logic              vld_reg;
    logic              res_reg;
    logic [HUE_W-1:0]  hue_reg, hue_next, q;
    logic [CHAN_W-1:0] sat_reg, sat_next, bri_reg, bri_next;
    logic              live;

    always_comb
    begin
        q    = HUE_W'(in_item.hq);
        live = in_item.ok && !in_item.zero_c;
        case (in_item.sector)
            SEC_RED:   hue_next = !in_item.neg ? q : ((q == '0) ? '0 : HUE_FULL - q);
            SEC_GREEN: hue_next = in_item.neg ? HUE_GREEN - q : HUE_GREEN + q;
            SEC_BLUE:  hue_next = in_item.neg ? HUE_BLUE - q : HUE_BLUE + q;
            default:   hue_next = '0;
        endcase
        if (!live)
            hue_next = '0;
        sat_next = live ? in_item.sq : '0;
        bri_next = in_item.ok ? in_item.mx : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= in_item.ok;
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            bri_reg <= bri_next;
        end
    end

    assign out_vld    = vld_reg;
    assign valid_res  = res_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bri_reg;

endmodule

// ===== hdl/rgb_to_hsv_convert.sv =====
`timescale 1ns / 1ps
// pixels reach hsv_valid via rhc_front, the divide stages and the rhc_back output register
// throughput: one item per clock; the whole pipeline holds while the output item is stalled
// the depth is set by the one-bit-per-stage saturation and hue dividers
// reset: rst_n clears every stage valid bit asynchronously; payload registers are not reset
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert
// pipelined conversion of a fixed-point rgb pixel to hue, saturation, value
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // pixel input channel
    input  logic                       pix_valid,
    output logic                       pix_stall,
    input  logic [rhc_pkg::CHAN_W-1:0] red,
    input  logic [rhc_pkg::CHAN_W-1:0] green,
    input  logic [rhc_pkg::CHAN_W-1:0] blue,
    // hsv output channel
    output logic                       hsv_valid,
    input  logic                       hsv_stall,
    output logic                       valid_res,
    output logic [rhc_pkg::HUE_W-1:0]  hue,
    output logic [rhc_pkg::CHAN_W-1:0] saturation,
    output logic [rhc_pkg::CHAN_W-1:0] brightness
);
    import rhc_pkg::*;

    // saturation needs FRAC_BITS+1 quotient bits, hue needs 12
    localparam int SAT_STEPS = FRAC_BITS + 1;
    localparam int DIV_STAGES = (SAT_STEPS > HQ_W) ? SAT_STEPS : HQ_W;

    logic  en;
    logic  vld [DIV_STAGES+1];
    item_t item [DIV_STAGES+1];

    // every stage advances together unless a finished item is held at the output
    assign en        = !(hsv_valid && hsv_stall);
    assign pix_stall = !en;

    // input register, max/min search, hue numerator multiply
    rhc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (pix_valid),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .out_vld  (vld[0]),
        .out_item (item[0])
    );

    // one quotient bit of each divider per stage; the shorter one passes through
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        rhc_div_stage #(
            .DO_SAT    (s < SAT_STEPS),
            .SAT_FIRST (s == 0),
            .DO_HUE    (s < HQ_W)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (vld[s]),
            .in_item  (item[s]),
            .out_vld  (vld[s+1]),
            .out_item (item[s+1])
        );
    end

    // sector offset, grey and out-of-range cases, output register
    rhc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (vld[DIV_STAGES]),
        .in_item    (item[DIV_STAGES]),
        .out_vld    (hsv_valid),
        .valid_res  (valid_res),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

endmodule

// ===== tb/tb_rgb_to_hsv_convert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_convert
// drives rgb pixels into the converter with random gaps and output stalls,
// predicts hue, saturation and value for every accepted pixel and checks
// each output item against the oldest prediction, in order
// ----------------------------------------------------------------------------

// expected hsv items in flight, checked in order
class hsv_scoreboard;
    typedef struct {
        logic                       ok;
        logic [rhc_pkg::HUE_W-1:0]  h;
        logic [rhc_pkg::CHAN_W-1:0] s;
        logic [rhc_pkg::CHAN_W-1:0] v;
    } hsv_t;

    hsv_t pending[$];
    int   errors;

    function new();
        errors = 0;
    endfunction

    // work out hsv for one accepted pixel
    function void note_pixel(logic [16:0] r, logic [16:0] g, logic [16:0] b);
        longint one, mx, mn, c, d, q, h;
        hsv_t   e;
        one = longint'(1) << 16;
        e.ok = 0;
        e.h  = '0;
        e.s  = '0;
        e.v  = '0;
        if (r <= one && g <= one && b <= one)
        begin
            mx = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            mn = r;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            c = mx - mn;
            e.ok = 1;
            e.v  = mx[16:0];
            if (c != 0)
            begin
                // red wins ties, then green
                if (mx == r)      d = longint'(g) - longint'(b);
                else if (mx == g) d = longint'(b) - longint'(r);
                else              d = longint'(r) - longint'(g);
                q = ((d < 0 ? -d : d) * 3840) / c;
                if (d < 0) q = -q;
                if (mx == r)
                begin
                    h = q;
                    if (h < 0) h = h + 23040;
                end
                else if (mx == g) h = q + 7680;
                else              h = q + 15360;
                e.h = h[14:0];
                e.s = 17'((c << 16) / mx);
            end
        end
        pending.push_back(e);
    endfunction

    function void check_hsv(logic ok, logic [14:0] h, logic [16:0] s, logic [16:0] v);
        hsv_t e;
        if (pending.size() == 0)
        begin
            $error("hsv item with no pixel pending");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (ok !== e.ok)
        begin
            $error("valid_res expected %0d actual %0d", e.ok, ok);
            errors++;
        end
        if (h !== e.h)
        begin
            $error("hue expected %0d actual %0d", e.h, h);
            errors++;
        end
        if (s !== e.s)
        begin
            $error("saturation expected %0d actual %0d", e.s, s);
            errors++;
        end
        if (v !== e.v)
        begin
            $error("brightness expected %0d actual %0d", e.v, v);
            errors++;
        end
    endfunction
endclass

module tb_rgb_to_hsv_convert;
    import rhc_pkg::*;

    localparam logic [16:0] ONE = 17'd65536;
    localparam int LATENCY = 21;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              pix_valid = 0;
    logic              pix_stall;
    logic [CHAN_W-1:0] red = '0;
    logic [CHAN_W-1:0] green = '0;
    logic [CHAN_W-1:0] blue = '0;
    logic              hsv_valid;
    logic              hsv_stall = 0;
    logic              valid_res;
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;

    hsv_scoreboard sb = new();
    bit            stim_done = 0;

    always #2 clk = ~clk;

    rgb_to_hsv_convert u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .hsv_valid  (hsv_valid),
        .hsv_stall  (hsv_stall),
        .valid_res  (valid_res),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // a channel value biased toward the interesting spots
    function automatic logic [16:0] pick_chan();
        int p;
        p = $urandom_range(99);
        if (p < 3)  return 17'($urandom_range(131071, ONE + 1));   // out of range
        if (p < 8)  return ONE;
        if (p < 12) return 17'($urandom_range(3));
        return 17'($urandom_range(ONE));
    endfunction

    // one pixel: hold until accepted, then optionally drop valid for a gap
    task automatic send_pixel(logic [16:0] r, logic [16:0] g, logic [16:0] b, bit hold_on);
        int gap;
        pix_valid <= 1'b1;
        red       <= r;
        green     <= g;
        blue      <= b;
        @(posedge clk);
        while (pix_stall) @(posedge clk);
        sb.note_pixel(r, g, b);
        gap = hold_on ? 0 : pick_gap();
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_rgb(logic [16:0] r, logic [16:0] g, logic [16:0] b);
        send_pixel(r, g, b, 1'b0);
    endtask

    // output checking, sampled at the edge where the handshake completes
    always @(posedge clk)
        if (rst_n && hsv_valid && !hsv_stall)
            sb.check_hsv(valid_res, hue, saturation, brightness);

    // receiver back-pressure, with calm stretches
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = pick_gap();
            if ($urandom_range(9) == 0)
            begin
                hsv_stall <= 1'b0;
                repeat ($urandom_range(200, 50)) @(posedge clk);
            end
            else if (n > 0)
            begin
                hsv_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            hsv_stall <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    end

    initial
    begin
        int i;
        int mode;
        int base;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: corners, every sector, ties, grey, out of range
        send_rgb(0, 0, 0);                       // black
        send_rgb(ONE, ONE, ONE);                 // white
        send_rgb(ONE / 2, ONE / 2, ONE / 2);     // grey
        send_rgb(ONE, 0, 0);                     // pure red
        send_rgb(0, ONE, 0);                     // pure green
        send_rgb(0, 0, ONE);                     // pure blue
        send_rgb(ONE, 0, ONE / 3);               // red sector, wraps negative
        send_rgb(ONE, 0, 1);                     // red sector, tiny negative
        send_rgb(ONE, 1, 0);
        send_rgb(65535, 0, 65534);               // negative red quotient truncates to nonzero
        send_rgb(100, 99, 100);                  // red-blue tie, red wins
        send_rgb(50, 100, 100);                  // green-blue tie, green wins
        send_rgb(100, 100, 0);                   // red-green tie
        send_rgb(1, 0, ONE);                     // blue sector
        send_rgb(ONE, ONE, 0);
        send_rgb(0, ONE, ONE);
        send_rgb(ONE + 1, 0, 0);                 // just out of range
        send_rgb(0, ONE + 1, 0);
        send_rgb(0, 0, 17'h1FFFF);
        send_rgb(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        send_rgb(1, 0, 0);                       // smallest chroma
        send_rgb(17'h0AAAA, 17'h15555 & 17'hFFFF, 17'h05555);

        // hold off until the pipe drains completely
        pix_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);

        // random part, some bursts with no idling
        for (i = 0; i < 1800; i++)
        begin
            mode = $urandom_range(9);
            if (mode < 6)
                send_pixel(pick_chan(), pick_chan(), pick_chan(), (i % 300) < 40);
            else if (mode < 8)
            begin
                // near-grey pixels, small chroma stresses the divide
                base = $urandom_range(ONE - 4);
                send_pixel(17'(base + $urandom_range(4)), 17'(base + $urandom_range(4)),
                           17'(base + $urandom_range(4)), 1'b0);
            end
            else
                send_pixel(17'($urandom), 17'($urandom), 17'($urandom), 1'b0);
        end
        pix_valid <= 1'b0;
        stim_done = 1;
    end

    // end of run once everything has drained
    initial
    begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
